@@ design/ps2_mouse_packet_tracker_unit_assert.svh @@
// Assertion macros for the PS/2 mouse packet tracker.
// No dependencies; included inside module bodies that check their own logic.
`ifndef PS2_MOUSE_PACKET_TRACKER_UNIT_ASSERT_SVH
`define PS2_MOUSE_PACKET_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PMPT_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("pmpt same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PMPT_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("pmpt next-cycle check failed");

`endif

@@ design/pmpt_pkg.sv @@
// Shared constants for the PS/2 mouse packet tracker.
// No dependencies; used by the interfaces, the clamp unit and the top level.
package pmpt_pkg;

   localparam int COORD_WIDTH_DEF = 12;
   localparam int SIZE_WIDTH      = 13;
   localparam int BYTE_WIDTH      = 8;
   localparam int BUTTON_WIDTH    = 3;
   localparam int DELTA_WIDTH     = 10;   // 9-bit signed delta, negated without overflow

   localparam logic [SIZE_WIDTH-1:0] SCREEN_WIDTH_RST  = 13'd1024;
   localparam logic [SIZE_WIDTH-1:0] SCREEN_HEIGHT_RST = 13'd768;
   localparam int RESET_X = 512;
   localparam int RESET_Y = 384;

   // header byte bit positions
   localparam int HDR_SYNC_BIT   = 3;
   localparam int HDR_X_SIGN_BIT = 4;
   localparam int HDR_Y_SIGN_BIT = 5;

   // register indexes
   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

endpackage

@@ design/pmpt_if.sv @@
// Valid/ready channel interfaces for the PS/2 mouse packet tracker.
// Depends on pmpt_pkg for field widths.
interface pmpt_req_if;
   logic                              valid;
   logic                              ready;
   logic [pmpt_pkg::BYTE_WIDTH-1:0]   rx_byte;
   logic                              from_aux;

   modport source (output valid, rx_byte, from_aux, input ready);
   modport sink   (input valid, rx_byte, from_aux, output ready);
endinterface

interface pmpt_rsp_if #(
   parameter int COORD_WIDTH = pmpt_pkg::COORD_WIDTH_DEF
);
   logic                                valid;
   logic                                ready;
   logic [COORD_WIDTH-1:0]              cursor_x;
   logic [COORD_WIDTH-1:0]              cursor_y;
   logic [pmpt_pkg::BUTTON_WIDTH-1:0]   button_bits;
   logic                                packet_done;

   modport source (output valid, cursor_x, cursor_y, button_bits, packet_done, input ready);
   modport sink   (input valid, cursor_x, cursor_y, button_bits, packet_done, output ready);
endinterface

@@ design/ps2_mouse_packet_tracker_unit.sv @@
// PS/2 mouse packet tracker: one beat per cycle sustained unless rsp stalls. The byte sits in
// an input register, one pass of phase decode and add/clamp logic feeds the cursor state and
// the rsp register in the same edge. req_ready drops only when both registers are full and
// rsp is stalled. Synchronous active-high reset: cursor at (512, 384) saturated to the
// coordinate range, buttons 0, screen 1024 x 768, no beats in flight.
module ps2_mouse_packet_tracker_unit #(
   parameter int COORD_WIDTH = pmpt_pkg::COORD_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   pmpt_req_if.sink                         req_ch,
   pmpt_rsp_if.source                       rsp_ch,
   input  logic                             csr_write_en,
   input  logic                             csr_index,
   input  logic [pmpt_pkg::SIZE_WIDTH-1:0]  csr_wdata
);
   import pmpt_pkg::*;

   `include "ps2_mouse_packet_tracker_unit_assert.svh"

   // reset position, saturated to what the coordinate width can hold
   localparam int COORD_MAX = (1 << COORD_WIDTH) - 1;
   localparam logic [COORD_WIDTH-1:0] POS_X_RST =
      COORD_WIDTH'((RESET_X > COORD_MAX) ? COORD_MAX : RESET_X);
   localparam logic [COORD_WIDTH-1:0] POS_Y_RST =
      COORD_WIDTH'((RESET_Y > COORD_MAX) ? COORD_MAX : RESET_Y);

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_X      = 2'd1,
      PH_Y      = 2'd2
   } phase_type;

   // input stage
   logic                     in_valid_ff;
   logic [BYTE_WIDTH-1:0]    in_byte_ff;
   logic                     in_aux_ff;

   // tracker state
   phase_type                phase_ff, phase_in;
   logic [BYTE_WIDTH-1:0]    hdr_ff, hdr_in;
   logic [BYTE_WIDTH-1:0]    xb_ff, xb_in;
   logic [COORD_WIDTH-1:0]   pos_x_ff, pos_x_in;
   logic [COORD_WIDTH-1:0]   pos_y_ff, pos_y_in;
   logic [BUTTON_WIDTH-1:0]  btn_ff, btn_in;
   logic                     done_in;

   // configuration
   logic [SIZE_WIDTH-1:0]    scr_w_ff;
   logic [SIZE_WIDTH-1:0]    scr_h_ff;

   // result register
   logic                     rsp_valid_ff;
   logic [COORD_WIDTH-1:0]   rsp_x_ff;
   logic [COORD_WIDTH-1:0]   rsp_y_ff;
   logic [BUTTON_WIDTH-1:0]  rsp_btn_ff;
   logic                     rsp_done_ff;

   logic                     advance;
   logic signed [DELTA_WIDTH-1:0] dx;
   logic signed [DELTA_WIDTH-1:0] dy_neg;
   logic [COORD_WIDTH-1:0]   clamp_x;
   logic [COORD_WIDTH-1:0]   clamp_y;

   // input register moves on whenever the rsp register is free or being drained
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         in_byte_ff <= req_ch.rx_byte;
         in_aux_ff  <= req_ch.from_aux;
      end
   end

   // deltas: 9-bit two's complement with the sign bit from the header.
   // Y is screen-downward, so its delta is negated.
   assign dx     = DELTA_WIDTH'($signed({hdr_ff[HDR_X_SIGN_BIT], xb_ff}));
   assign dy_neg = -DELTA_WIDTH'($signed({hdr_ff[HDR_Y_SIGN_BIT], in_byte_ff}));

   pmpt_axis_clamp #(.COORD_WIDTH(COORD_WIDTH)) u_clamp_x (
      .pos_i   (pos_x_ff),
      .delta_i (dx),
      .size_i  (scr_w_ff),
      .pos_o   (clamp_x)
   );

   pmpt_axis_clamp #(.COORD_WIDTH(COORD_WIDTH)) u_clamp_y (
      .pos_i   (pos_y_ff),
      .delta_i (dy_neg),
      .size_i  (scr_h_ff),
      .pos_o   (clamp_y)
   );

   // packet assembly; non-mouse bytes leave everything untouched
   always_comb begin
      phase_in = phase_ff;
      hdr_in   = hdr_ff;
      xb_in    = xb_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      btn_in   = btn_ff;
      done_in  = 1'b0;
      if (in_aux_ff) begin
         case (phase_ff)
            PH_X: begin
               xb_in    = in_byte_ff;
               phase_in = PH_Y;
            end
            PH_Y: begin
               pos_x_in = clamp_x;
               pos_y_in = clamp_y;
               btn_in   = hdr_ff[BUTTON_WIDTH-1:0];
               phase_in = PH_HEADER;
               done_in  = 1'b1;
            end
            default: begin
               // header must carry the always-one sync bit, else drop it
               if (in_byte_ff[HDR_SYNC_BIT]) begin
                  hdr_in   = in_byte_ff;
                  phase_in = PH_X;
               end else begin
                  phase_in = PH_HEADER;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_HEADER;
         hdr_ff       <= '0;
         xb_ff        <= '0;
         pos_x_ff     <= POS_X_RST;
         pos_y_ff     <= POS_Y_RST;
         btn_ff       <= '0;
         scr_w_ff     <= SCREEN_WIDTH_RST;
         scr_h_ff     <= SCREEN_HEIGHT_RST;
         rsp_x_ff     <= POS_X_RST;
         rsp_y_ff     <= POS_Y_RST;
         rsp_btn_ff   <= '0;
         rsp_done_ff  <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            phase_ff     <= phase_in;
            hdr_ff       <= hdr_in;
            xb_ff        <= xb_in;
            pos_x_ff     <= pos_x_in;
            pos_y_ff     <= pos_y_in;
            btn_ff       <= btn_in;
            rsp_valid_ff <= 1'b1;
            rsp_x_ff     <= pos_x_in;
            rsp_y_ff     <= pos_y_in;
            rsp_btn_ff   <= btn_in;
            rsp_done_ff  <= done_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:  scr_w_ff <= csr_wdata;
               CSR_SCREEN_HEIGHT: scr_h_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.cursor_x    = rsp_x_ff;
   assign rsp_ch.cursor_y    = rsp_y_ff;
   assign rsp_ch.button_bits = rsp_btn_ff;
   assign rsp_ch.packet_done = rsp_done_ff;

   // a pending packet has a header that carried the sync bit
   `PMPT_ASSERT_NOW(a_hdr_sync, clock, reset, phase_ff != PH_HEADER, hdr_ff[HDR_SYNC_BIT])
   // the third mouse byte closes the packet and rewinds the phase
   `PMPT_ASSERT_NEXT(a_pkt_close, clock, reset, advance && in_aux_ff && phase_ff == PH_Y, rsp_ch.valid && rsp_ch.packet_done && phase_ff == PH_HEADER)
   // buttons of a finished packet are the latched header bits
   `PMPT_ASSERT_NOW(a_pkt_btn, clock, reset, rsp_ch.valid && rsp_ch.packet_done, rsp_ch.button_bits == hdr_ff[BUTTON_WIDTH-1:0])

endmodule

@@ design/pmpt_axis_clamp.sv @@
// One cursor axis: adds a signed delta and clamps to [0, screen size - 1],
// with the limit saturated to the coordinate range. Depends on pmpt_pkg.
module pmpt_axis_clamp #(
   parameter int COORD_WIDTH = pmpt_pkg::COORD_WIDTH_DEF
) (
   input  logic [COORD_WIDTH-1:0]                  pos_i,
   input  logic signed [pmpt_pkg::DELTA_WIDTH-1:0] delta_i,
   input  logic [pmpt_pkg::SIZE_WIDTH-1:0]         size_i,
   output logic [COORD_WIDTH-1:0]                  pos_o
);
   import pmpt_pkg::*;

   localparam int LW   = (COORD_WIDTH > SIZE_WIDTH) ? COORD_WIDTH : SIZE_WIDTH;
   localparam int CMPW = LW + 2;

   logic [SIZE_WIDTH-1:0]  size_m1;
   logic [LW-1:0]          size_ext;
   logic [LW-1:0]          coord_max;
   logic [LW-1:0]          lim;
   logic signed [CMPW-1:0] sum;
   logic signed [CMPW-1:0] lim_s;

   // a size of zero behaves like one
   assign size_m1   = (size_i == '0) ? '0 : size_i - 1'b1;
   assign size_ext  = LW'(size_m1);
   assign coord_max = LW'({COORD_WIDTH{1'b1}});
   assign lim       = (size_ext > coord_max) ? coord_max : size_ext;

   assign sum   = $signed(CMPW'(pos_i)) + CMPW'(delta_i);
   assign lim_s = $signed(CMPW'(lim));

   always_comb begin
      if (sum < 0) begin
         pos_o = '0;
      end else if (sum > lim_s) begin
         pos_o = COORD_WIDTH'(lim);
      end else begin
         pos_o = COORD_WIDTH'(sum);
      end
   end

endmodule
